/* rtl/fau_pkg.sv */
// ----------------------------------------------------------------------------
// fau_pkg
// Shared types, operation codes and division unit handshake for the fraction
// arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none
package fau_pkg;
  localparam int unsigned W = 32;

  typedef enum logic [1:0] {
    OP_REDUCE = 2'd0,
    OP_COMPARE = 2'd1,
    OP_ADD = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ORD_LESS = 2'd0,
    ORD_EQUAL = 2'd1,
    ORD_GREATER = 2'd2
  } order_t;

  typedef struct packed {
    logic          go;
    logic [W-1:0]  dividend;
    logic [W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [W-1:0]  quot;
    logic [W-1:0]  rem;
  } div_rsp_t;

  function automatic logic [W-1:0] mag(input logic [W-1:0] x);
    mag = x[W-1] ? (~x + {{(W-1){1'b0}}, 1'b1}) : x;
  endfunction
endpackage
`default_nettype wire

/* rtl/fau_div.sv */
// ----------------------------------------------------------------------------
// fau_div
// Signed truncated division, one quotient bit per cycle (restoring).
// ----------------------------------------------------------------------------
`default_nettype none
module fau_div (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire fau_pkg::div_req_t req,
  output fau_pkg::div_rsp_t     rsp
);
  localparam int unsigned W = fau_pkg::W;

  logic [W-1:0] rem_r, rem_nxt, quo_r, quo_nxt, dsr_r, dsr_nxt;
  logic         qneg_r, qneg_nxt, rneg_r, rneg_nxt;
  logic [5:0]   cnt_r, cnt_nxt;
  logic         busy_r, busy_nxt, done_r, done_nxt;
  logic [W:0]   trial, diff;

  always_comb begin
    trial = {rem_r, quo_r[W-1]};
    diff = trial - {1'b0, dsr_r};
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    dsr_nxt = dsr_r;
    qneg_nxt = qneg_r;
    rneg_nxt = rneg_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.go) begin
      rem_nxt = '0;
      quo_nxt = fau_pkg::mag(req.dividend);
      dsr_nxt = fau_pkg::mag(req.divisor);
      qneg_nxt = req.dividend[W-1] ^ req.divisor[W-1];
      rneg_nxt = req.dividend[W-1];
      cnt_nxt = 6'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[W]) begin
        rem_nxt = diff[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
    qneg_r <= qneg_nxt;
    rneg_r <= rneg_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = qneg_r ? (~quo_r + 32'd1) : quo_r;
  assign rsp.rem = rneg_r ? (~rem_r + 32'd1) : rem_r;
endmodule
`default_nettype wire

/* rtl/fraction_arithmetic_unit_core.sv */
// ----------------------------------------------------------------------------
// fraction_arithmetic_unit_core
// Sequencer around a shared multiplier and a bit-serial divider.
// ----------------------------------------------------------------------------
// One request at a time: busy rises after start and falls with the single
// out_valid strobe; results cannot be held off. Each division runs in the
// shared divider. Reduce runs one division per Euclid step (at most
// about 46) plus two more; add first forms its products on the multiplier
// and then reduces; compare takes two divisions and multiplier products.
`default_nettype none
module fraction_arithmetic_unit_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [31:0] in_first_num,
  input  wire logic [31:0] in_first_den,
  input  wire logic [31:0] in_second_num,
  input  wire logic [31:0] in_second_den,
  output logic             out_valid,
  output logic [31:0]      out_res_num,
  output logic [31:0]      out_res_den,
  output logic [1:0]       out_order,
  output logic             out_status
);
  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_MUL  = 11'b00000000010,
    S_EUC  = 11'b00000000100,
    S_EUCW = 11'b00000001000,
    S_DN   = 11'b00000010000,
    S_DNW  = 11'b00000100000,
    S_DD   = 11'b00001000000,
    S_DDW  = 11'b00010000000,
    S_C1W  = 11'b00100000000,
    S_C2W  = 11'b01000000000,
    S_DONE = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;
  fau_pkg::op_t op_r, op_nxt;
  logic [31:0] n1_r, d1_r, n2_r, d2_r, n1_nxt, d1_nxt, n2_nxt, d2_nxt;
  logic [31:0] a_r, b_r, a_nxt, b_nxt, acc_r, acc_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [31:0] rn_r, rd_r, rn_nxt, rd_nxt;
  logic [1:0]  ord_r, ord_nxt;
  logic        st_r, st_nxt, vld_r, vld_nxt;
  logic [31:0] mx, my, prod;
  fau_pkg::div_req_t dreq;
  fau_pkg::div_rsp_t drsp;

  fau_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign prod = mx * my;

  always_comb begin
    state_nxt = state_r; op_nxt = op_r;
    n1_nxt = n1_r; d1_nxt = d1_r; n2_nxt = n2_r; d2_nxt = d2_r;
    a_nxt = a_r; b_nxt = b_r; acc_nxt = acc_r; step_nxt = step_r;
    rn_nxt = rn_r; rd_nxt = rd_r; ord_nxt = ord_r; st_nxt = st_r;
    vld_nxt = 1'b0;
    mx = '0; my = '0;
    dreq = '0;
    unique case (state_r)
      S_IDLE: if (start && !busy) begin
        op_nxt = fau_pkg::op_t'(in_req_type);
        n1_nxt = in_first_num; d1_nxt = in_first_den;
        n2_nxt = in_second_num; d2_nxt = in_second_den;
        rn_nxt = '0; rd_nxt = '0; ord_nxt = fau_pkg::ORD_LESS; st_nxt = 1'b0;
        step_nxt = '0;
        unique case (fau_pkg::op_t'(in_req_type))
          fau_pkg::OP_REDUCE: begin
            a_nxt = in_first_num; b_nxt = in_first_den; state_nxt = S_EUC;
          end
          fau_pkg::OP_ADD: state_nxt = S_MUL;
          fau_pkg::OP_COMPARE:
            if (in_first_den == '0 || in_second_den == '0) begin
              st_nxt = 1'b1; state_nxt = S_DONE;
            end else state_nxt = S_MUL;
          default: state_nxt = S_DONE;
        endcase
      end
      S_MUL: begin
        step_nxt = step_r + 3'd1;
        if (op_r == fau_pkg::OP_ADD) begin
          unique case (step_r)
            3'd0: begin mx = n1_r; my = d2_r; acc_nxt = prod; end
            3'd1: begin mx = d1_r; my = n2_r; a_nxt = acc_r + prod; end
            default: begin
              mx = d1_r; my = d2_r; b_nxt = prod;
              n1_nxt = a_r; d1_nxt = prod; state_nxt = S_EUC;
            end
          endcase
        end else begin
          // hold m1 in a_r, m2 in b_r via two divisions
          unique case (step_r)
            3'd0: begin mx = n1_r; my = d1_r;
              dreq.go = 1'b1; dreq.dividend = prod;
              dreq.divisor = fau_pkg::mag(d1_r); state_nxt = S_C1W; end
            3'd1: begin mx = n2_r; my = d2_r;
              dreq.go = 1'b1; dreq.dividend = prod;
              dreq.divisor = fau_pkg::mag(d2_r); state_nxt = S_C2W; end
            3'd2: begin mx = a_r; my = fau_pkg::mag(d2_r); acc_nxt = prod; end
            default: begin
              mx = b_r; my = fau_pkg::mag(d1_r);
              if ($signed(prod) < $signed(acc_r)) ord_nxt = fau_pkg::ORD_GREATER;
              else if (prod == acc_r) ord_nxt = fau_pkg::ORD_EQUAL;
              else ord_nxt = fau_pkg::ORD_LESS;
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_C1W: if (drsp.done) begin a_nxt = drsp.quot; state_nxt = S_MUL; end
      S_C2W: if (drsp.done) begin b_nxt = drsp.quot; state_nxt = S_MUL; end
      S_EUC:
        if (b_r != '0) begin
          dreq.go = 1'b1; dreq.dividend = a_r; dreq.divisor = b_r;
          state_nxt = S_EUCW;
        end else if (a_r == '0) begin
          st_nxt = 1'b1; state_nxt = S_DONE;
        end else state_nxt = S_DN;
      S_EUCW: if (drsp.done) begin
        a_nxt = b_r; b_nxt = drsp.rem; state_nxt = S_EUC;
      end
      S_DN: begin
        dreq.go = 1'b1; dreq.dividend = n1_r; dreq.divisor = a_r; state_nxt = S_DNW;
      end
      S_DNW: if (drsp.done) begin rn_nxt = drsp.quot; state_nxt = S_DD; end
      S_DD: begin
        dreq.go = 1'b1; dreq.dividend = d1_r; dreq.divisor = a_r; state_nxt = S_DDW;
      end
      S_DDW: if (drsp.done) begin rd_nxt = drsp.quot; state_nxt = S_DONE; end
      S_DONE: begin vld_nxt = 1'b1; state_nxt = S_IDLE; end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vld_r <= vld_nxt;
    end
    op_r <= op_nxt; step_r <= step_nxt;
    n1_r <= n1_nxt; d1_r <= d1_nxt; n2_r <= n2_nxt; d2_r <= d2_nxt;
    a_r <= a_nxt; b_r <= b_nxt; acc_r <= acc_nxt;
    rn_r <= rn_nxt; rd_r <= rd_nxt; ord_r <= ord_nxt; st_r <= st_nxt;
  end

  assign busy = (state_r != S_IDLE) || vld_r;
  assign out_valid = vld_r;
  assign out_res_num = rn_r;
  assign out_res_den = rd_r;
  assign out_order = ord_r;
  assign out_status = st_r;

  a_vld_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("strobe outside busy");
  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double strobe");
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_res_num == '0 && out_res_den == '0))
    else $error("status with nonzero result");
endmodule
`default_nettype wire

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for fraction_arithmetic_unit_core: a directed table of
// edge cases followed by random requests, each result checked field by field
// against a local fraction predictor (Euclid gcd reduce, add, compare).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned RANDOM_ITEMS = 300;
  localparam logic [31:0] MINV = 32'h8000_0000;
  localparam logic [31:0] MAXV = 32'h7fff_ffff;

  typedef struct packed {
    fau_pkg::op_t op;
    logic [31:0]  n1;
    logic [31:0]  d1;
    logic [31:0]  n2;
    logic [31:0]  d2;
  } request_t;

  typedef struct packed {
    logic [31:0]     num;
    logic [31:0]     den;
    fau_pkg::order_t ord;
    logic            st;
  } fraction_result_t;

  typedef struct packed {
    request_t         req;
    logic             known;
    fraction_result_t res;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_req_type;
  logic [31:0] in_first_num, in_first_den, in_second_num, in_second_den;
  logic        out_valid;
  logic [31:0] out_res_num, out_res_den;
  logic [1:0]  out_order;
  logic        out_status;

  fraction_result_t expected_results[$];
  int unsigned      mismatches;
  int unsigned      table_errors;
  int unsigned      cycles;
  stim_row_t        directed_rows[$];

  fraction_arithmetic_unit_core i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_first_num(in_first_num),
    .in_first_den(in_first_den), .in_second_num(in_second_num),
    .in_second_den(in_second_den), .out_valid(out_valid),
    .out_res_num(out_res_num), .out_res_den(out_res_den),
    .out_order(out_order), .out_status(out_status)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [31:0] abs_wrap(logic [31:0] x);
    return x[31] ? 32'd0 - x : x;
  endfunction

  function automatic logic [31:0] trunc_div(logic [31:0] a, logic [31:0] b);
    logic [31:0] q;
    q = abs_wrap(a) / abs_wrap(b);
    return (a[31] ^ b[31]) ? 32'd0 - q : q;
  endfunction

  function automatic logic [31:0] trunc_rem(logic [31:0] a, logic [31:0] b);
    logic [31:0] r;
    r = abs_wrap(a) % abs_wrap(b);
    return a[31] ? 32'd0 - r : r;
  endfunction

  function automatic fraction_result_t reduce_fraction(logic [31:0] n, logic [31:0] d);
    fraction_result_t r;
    logic [31:0] a, b, t;
    r = '0;
    a = n;
    b = d;
    while (b != 0) begin
      t = a;
      a = b;
      b = trunc_rem(t, a);
    end
    if (a == 0) begin
      r.st = 1'b1;
    end else begin
      r.num = trunc_div(n, a);
      r.den = trunc_div(d, a);
    end
    return r;
  endfunction

  function automatic fraction_result_t predict_fraction(request_t q);
    fraction_result_t r;
    logic [31:0] a1, a2, v1, v2;
    r = '0;
    case (q.op)
      fau_pkg::OP_REDUCE: r = reduce_fraction(q.n1, q.d1);
      fau_pkg::OP_ADD: r = reduce_fraction(q.n1 * q.d2 + q.d1 * q.n2, q.d1 * q.d2);
      fau_pkg::OP_COMPARE: begin
        if (q.d1 == 0 || q.d2 == 0) begin
          r.st = 1'b1;
        end else begin
          a1 = abs_wrap(q.d1);
          a2 = abs_wrap(q.d2);
          v1 = trunc_div(q.n1 * q.d1, a1) * a2;
          v2 = trunc_div(q.n2 * q.d2, a2) * a1;
          if ($signed(v2) < $signed(v1)) r.ord = fau_pkg::ORD_GREATER;
          else if (v1 == v2) r.ord = fau_pkg::ORD_EQUAL;
          else r.ord = fau_pkg::ORD_LESS;
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic transfer_request(request_t q, int unsigned gap);
    repeat (gap) @(negedge clk);
    while (busy) @(negedge clk);
    in_req_type = q.op;
    in_first_num = q.n1;
    in_first_den = q.d1;
    in_second_num = q.n2;
    in_second_den = q.d2;
    start = 1'b1;
    @(posedge clk);
    expected_results.push_back(predict_fraction(q));
    @(negedge clk);
    start = 1'b0;
  endtask

  function automatic logic [31:0] random_value();
    case ($urandom_range(0, 5))
      0: return MINV;
      1: return MAXV;
      2: return 32'($signed($urandom_range(0, 40)) - 20);
      3: return 32'($urandom_range(0, 200));
      4: return $urandom_range(0, 1) ? 32'($urandom_range(1, 12)) * 32'h1000 : 32'd0 - 32'd6;
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10)
          $display("unexpected result num=%h den=%h", out_res_num, out_res_den);
      end else if (out_res_num !== expected_results[0].num ||
                   out_res_den !== expected_results[0].den ||
                   out_order !== expected_results[0].ord ||
                   out_status !== expected_results[0].st) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10)
          $display("mismatch: exp num=%h den=%h ord=%0d st=%0d got %h %h %0d %0d",
                   expected_results[0].num, expected_results[0].den,
                   expected_results[0].ord, expected_results[0].st,
                   out_res_num, out_res_den, out_order, out_status);
        void'(expected_results.pop_front());
      end else begin
        void'(expected_results.pop_front());
      end
    end
  end

  function automatic stim_row_t row(fau_pkg::op_t op, logic [31:0] n1, logic [31:0] d1,
                                    logic [31:0] n2, logic [31:0] d2, logic known,
                                    logic [31:0] rn, logic [31:0] rd,
                                    fau_pkg::order_t ord, logic st);
    stim_row_t s;
    s.req = '{op, n1, d1, n2, d2};
    s.known = known;
    s.res = '{rn, rd, ord, st};
    return s;
  endfunction

  initial begin
    request_t q;
    rst_n = 1'b0;
    start = 1'b0;
    in_req_type = '0;
    in_first_num = '0;
    in_first_den = '0;
    in_second_num = '0;
    in_second_den = '0;
    directed_rows = '{
      row(fau_pkg::OP_REDUCE, 0, 0, 0, 0, 1, 0, 0, fau_pkg::ORD_LESS, 1),
      row(fau_pkg::OP_REDUCE, 6, 4, 0, 0, 1, 3, 2, fau_pkg::ORD_LESS, 0),
      row(fau_pkg::OP_REDUCE, 0, 5, 0, 0, 1, 0, 1, fau_pkg::ORD_LESS, 0),
      row(fau_pkg::OP_REDUCE, 7, 0, 0, 0, 1, 1, 0, fau_pkg::ORD_LESS, 0),
      row(fau_pkg::OP_REDUCE, MINV, 32'hffffffff, 0, 0, 0, 0, 0, fau_pkg::ORD_LESS, 0),
      row(fau_pkg::OP_REDUCE, MINV, MINV, 0, 0, 1, 1, 1, fau_pkg::ORD_LESS, 0),
      row(fau_pkg::OP_REDUCE, MAXV, MINV, MAXV, MINV, 0, 0, 0, fau_pkg::ORD_LESS, 0),
      row(fau_pkg::OP_REDUCE, -6, 4, 0, 0, 0, 0, 0, fau_pkg::ORD_LESS, 0),
      row(fau_pkg::OP_ADD, 1, 2, 1, 3, 1, 5, 6, fau_pkg::ORD_LESS, 0),
      row(fau_pkg::OP_ADD, 0, 0, 0, 0, 1, 0, 0, fau_pkg::ORD_LESS, 1),
      row(fau_pkg::OP_ADD, MAXV, MINV, MINV, MAXV, 0, 0, 0, fau_pkg::ORD_LESS, 0),
      row(fau_pkg::OP_ADD, 1, 0, 1, 0, 1, 0, 0, fau_pkg::ORD_LESS, 1),
      row(fau_pkg::OP_ADD, -3, 5, 7, -9, 0, 0, 0, fau_pkg::ORD_LESS, 0),
      row(fau_pkg::OP_COMPARE, 1, 0, 1, 2, 1, 0, 0, fau_pkg::ORD_LESS, 1),
      row(fau_pkg::OP_COMPARE, 1, 2, 1, 0, 1, 0, 0, fau_pkg::ORD_LESS, 1),
      row(fau_pkg::OP_COMPARE, 1, 2, 2, 4, 1, 0, 0, fau_pkg::ORD_EQUAL, 0),
      row(fau_pkg::OP_COMPARE, 1, 3, 1, 2, 1, 0, 0, fau_pkg::ORD_LESS, 0),
      row(fau_pkg::OP_COMPARE, 1, 2, 1, 3, 1, 0, 0, fau_pkg::ORD_GREATER, 0),
      row(fau_pkg::OP_COMPARE, MINV, MINV, MAXV, MINV, 0, 0, 0, fau_pkg::ORD_LESS, 0),
      row(fau_pkg::OP_COMPARE, 3, -4, -3, 4, 0, 0, 0, fau_pkg::ORD_LESS, 0),
      row(fau_pkg::OP_COMPARE, MAXV, MAXV, MINV, 32'hffffffff, 0, 0, 0,
          fau_pkg::ORD_LESS, 0),
      row(fau_pkg::OP_NONE, MAXV, MINV, MAXV, MINV, 1, 0, 0, fau_pkg::ORD_LESS, 0),
      row(fau_pkg::OP_NONE, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
          1, 0, 0, fau_pkg::ORD_LESS, 0)
    };
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].known &&
          predict_fraction(directed_rows[i].req) != directed_rows[i].res) begin
        table_errors = table_errors + 1;
        $display("table row %0d disagrees with predictor", i);
      end
      transfer_request(directed_rows[i].req, $urandom_range(0, 2));
    end
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      q.op = fau_pkg::op_t'($urandom_range(0, 3));
      q.n1 = random_value();
      q.d1 = random_value();
      q.n2 = random_value();
      q.d2 = random_value();
      if (k % 60 == 30) begin
        while (expected_results.size() != 0) @(negedge clk);
      end
      transfer_request(q, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16));
    end
    while (expected_results.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (mismatches == 0 && table_errors == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
